// ===== hw/rtl/tdf_pkg.sv =====
// ----------------------------------------------------------------------------
// tdf_pkg
// Shared types and constants of the trial-division factorizer.
// ----------------------------------------------------------------------------
package tdf_pkg;

   // Default width of the value that is factorized (and of each factor)
   localparam int DEF_VALUE_WIDTH = 31;
   // Width of the signed input value
   localparam int IN_WIDTH        = 32;
   // First candidate divisor
   localparam int FIRST_DIVISOR   = 2;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_DECIDE
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;         // capture input value, reset divisor
      logic div_init;     // start a division of the remaining value by the divisor
      logic take_q;       // remaining value takes the quotient (with div_init)
      logic div_step;     // one restoring-division step
      logic d_inc;        // next candidate divisor
      logic emit_empty;   // write the "no factors" result
      logic emit_factor;  // write the divisor as a factor
      logic emit_final;   // write the remaining value as the final factor
   } dp_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic is_empty;     // captured input has no factors
      logic div_last;     // current step is the last one of the division
      logic d_gt_q;       // divisor exceeds quotient: remaining value is prime
      logic r_zero;       // division left no remainder
      logic slot_free;    // output register can take a result this cycle
   } dp_status_type;

endpackage

// ===== hw/rtl/tdf_ctrl.sv =====
// ----------------------------------------------------------------------------
// tdf_ctrl
// Controller of the factorizer: sequences load, trial divisions and emits.
// ----------------------------------------------------------------------------
module tdf_ctrl
   import tdf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.is_empty) begin
               if (status.slot_free) begin
                  cmd.emit_empty = 1'b1;
                  state_in       = ST_IDLE;
               end
            end else begin
               cmd.div_init = 1'b1;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.d_gt_q) begin
               // no divisor up to the square root: the rest is prime
               if (status.slot_free) begin
                  cmd.emit_final = 1'b1;
                  state_in       = ST_IDLE;
               end
            end else if (status.r_zero) begin
               // divisor found: emit it, keep it, continue with the quotient
               if (status.slot_free) begin
                  cmd.emit_factor = 1'b1;
                  cmd.take_q      = 1'b1;
                  cmd.div_init    = 1'b1;
                  state_in        = ST_DIV;
               end
            end else begin
               cmd.d_inc    = 1'b1;
               cmd.div_init = 1'b1;
               state_in     = ST_DIV;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/tdf_dpath.sv =====
// ----------------------------------------------------------------------------
// tdf_dpath
// Datapath of the factorizer: remaining value, candidate divisor, a
// radix-2 restoring divider and the result register.
// ----------------------------------------------------------------------------
module tdf_dpath
   import tdf_pkg::*;
#(
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [IN_WIDTH-1:0]    value,
   input  dp_cmd_type             cmd,
   output dp_status_type          status,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [VALUE_WIDTH-1:0] out_factor,
   output logic                   out_last,
   output logic                   out_empty
);

   localparam int CNT_W  = $clog2(VALUE_WIDTH);
   localparam int WIDE_W = (VALUE_WIDTH > IN_WIDTH) ? VALUE_WIDTH : IN_WIDTH;

   logic [VALUE_WIDTH-1:0] rem_ff,    rem_in;
   logic [VALUE_WIDTH-1:0] d_ff,      d_in;
   logic [VALUE_WIDTH-1:0] dvd_ff,    dvd_in;
   logic [VALUE_WIDTH-1:0] quo_ff,    quo_in;
   logic [VALUE_WIDTH-1:0] prem_ff,   prem_in;
   logic [CNT_W-1:0]       cnt_ff,    cnt_in;
   logic                   empty_ff,  empty_in;
   logic                   ovalid_ff, ovalid_in;
   logic [VALUE_WIDTH-1:0] factor_ff, factor_in;
   logic                   last_ff,   last_in;
   logic                   oempty_ff, oempty_in;

   logic [WIDE_W-1:0]      mag_w;
   logic [WIDE_W-1:0]      limit_w;
   logic [WIDE_W-1:0]      sat_w;
   logic                   in_empty;
   logic [VALUE_WIDTH:0]   trial;
   logic [VALUE_WIDTH:0]   diff;
   logic                   ge;
   logic                   slot_free;

   // Input conditioning: sign check, saturation to the value width
   always_comb begin
      mag_w    = WIDE_W'(value[IN_WIDTH-2:0]);
      limit_w  = WIDE_W'({VALUE_WIDTH{1'b1}});
      sat_w    = (mag_w > limit_w) ? limit_w : mag_w;
      in_empty = value[IN_WIDTH-1] || (mag_w <= WIDE_W'(1));
   end

   // One restoring-division step: shift in the next dividend bit, subtract
   always_comb begin
      trial = {prem_ff, dvd_ff[VALUE_WIDTH-1]};
      diff  = trial - {1'b0, d_ff};
      ge    = ~diff[VALUE_WIDTH];
   end

   assign slot_free = ~ovalid_ff | out_ready;

   // Next values of the working registers
   always_comb begin
      rem_in   = rem_ff;
      d_in     = d_ff;
      dvd_in   = dvd_ff;
      quo_in   = quo_ff;
      prem_in  = prem_ff;
      cnt_in   = cnt_ff;
      empty_in = empty_ff;
      if (cmd.load) begin
         rem_in   = sat_w[VALUE_WIDTH-1:0];
         d_in     = VALUE_WIDTH'(FIRST_DIVISOR);
         empty_in = in_empty;
      end
      if (cmd.d_inc) begin
         d_in = d_ff + VALUE_WIDTH'(1);
      end
      if (cmd.div_init) begin
         dvd_in  = cmd.take_q ? quo_ff : rem_ff;
         prem_in = '0;
         cnt_in  = '0;
         if (cmd.take_q) begin
            rem_in = quo_ff;
         end
      end
      if (cmd.div_step) begin
         prem_in = ge ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
         quo_in  = {quo_ff[VALUE_WIDTH-2:0], ge};
         dvd_in  = {dvd_ff[VALUE_WIDTH-2:0], 1'b0};
         cnt_in  = cnt_ff + CNT_W'(1);
      end
   end

   // Result register
   always_comb begin
      factor_in = factor_ff;
      last_in   = last_ff;
      oempty_in = oempty_ff;
      ovalid_in = ovalid_ff & ~out_ready;
      if (cmd.emit_empty) begin
         factor_in = '0;
         last_in   = 1'b1;
         oempty_in = 1'b1;
         ovalid_in = 1'b1;
      end
      if (cmd.emit_factor) begin
         factor_in = d_ff;
         last_in   = 1'b0;
         oempty_in = 1'b0;
         ovalid_in = 1'b1;
      end
      if (cmd.emit_final) begin
         factor_in = rem_ff;
         last_in   = 1'b1;
         oempty_in = 1'b0;
         ovalid_in = 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         ovalid_ff <= ovalid_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      d_ff      <= d_in;
      dvd_ff    <= dvd_in;
      quo_ff    <= quo_in;
      prem_ff   <= prem_in;
      empty_ff  <= empty_in;
      factor_ff <= factor_in;
      last_ff   <= last_in;
      oempty_ff <= oempty_in;
   end

   // Status to the controller
   always_comb begin
      status.is_empty  = empty_ff;
      status.div_last  = (cnt_ff == CNT_W'(VALUE_WIDTH - 1));
      status.d_gt_q    = (d_ff > quo_ff);
      status.r_zero    = (prem_ff == '0);
      status.slot_free = slot_free;
   end

   assign out_valid  = ovalid_ff;
   assign out_factor = factor_ff;
   assign out_last   = last_ff;
   assign out_empty  = oempty_ff;

   // A result is written only into a free output register
   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_empty || cmd.emit_factor || cmd.emit_final) |-> slot_free)
      else $error("result written over a pending result");

   // The divisor holds still through a division
   a_div_stable: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_step && $past(cmd.div_step)) |-> $stable(d_ff))
      else $error("divisor changed during division");

   // The partial remainder stays below the divisor
   a_prem_range: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (prem_ff < d_ff))
      else $error("partial remainder out of range");

   // Every real factor is at least two
   a_factor_min: assert property (@(posedge clock) disable iff (reset)
      (ovalid_ff && !oempty_ff) |-> (factor_ff >= VALUE_WIDTH'(FIRST_DIVISOR)))
      else $error("factor below two");

endmodule

// ===== hw/rtl/trial_division_factorizer_unit.sv =====
// ----------------------------------------------------------------------------
// trial_division_factorizer_unit
// Prime factorization of a signed integer by trial division.
//
//   Channel | Direction | Transfer content
//   req_*   | in        | tdata[31:0] value (signed)
//   rsp_*   | out       | tdata factor, tlast last, tuser empty_res
//
// Each trial runs VALUE_WIDTH steps of the shared bit-serial divider,
// followed by one decision step. An item is loaded and checked, then
// runs one trial per candidate divisor, up to the larger of the second
// largest prime factor and just above the square root of the largest,
// plus one per factor found before the last.
// Reset is synchronous, active high, and returns the unit to idle at once.
// A stalled result holds the divider only when the next result is ready;
// a new item is taken while the last result still waits.
// ----------------------------------------------------------------------------
module trial_division_factorizer_unit
   import tdf_pkg::*;
#(
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
   parameter int RSP_DATA_W  = ((VALUE_WIDTH + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [IN_WIDTH-1:0]   req_tdata,   // [31:0] value
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [VALUE_WIDTH-1:0] factor, zero pad
   output logic                  rsp_tlast,
   output logic                  rsp_tuser    // [0] empty_res
);

   dp_cmd_type             cmd;
   dp_status_type          status;
   logic [VALUE_WIDTH-1:0] factor;

   tdf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tdf_dpath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .value      (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_factor (factor),
      .out_last   (rsp_tlast),
      .out_empty  (rsp_tuser)
   );

   assign rsp_tdata = RSP_DATA_W'(factor);

endmodule
